### hdl/tlsd_pkg.sv
// ----------------------------------------------------------------------------
// tlsd_pkg
// Shared widths, constants and the result record of the type-length deframer.
// ----------------------------------------------------------------------------
package tlsd_pkg;

  localparam int LENGTH_BITS_DEFAULT = 23;
  localparam int BYTE_BITS = 8;
  localparam int TYPE_BITS = 16;
  localparam int LEN_OUT_BITS = 23;
  localparam int CFG_BITS = 23;
  localparam int HDR_LEN_BITS = 32;
  localparam int TYPE_BYTES = 2;
  localparam int HDR_BYTES = 6;
  localparam int HDR_CNT_BITS = 3;

  localparam logic [LEN_OUT_BITS-1:0] HARD_MAX = 23'h7fffff;

  typedef struct packed {
    logic [TYPE_BITS-1:0]    message_type;
    logic [LEN_OUT_BITS-1:0] payload_length;
    logic [BYTE_BITS-1:0]    data_byte;
    logic                    has_data;
    logic                    last;
    logic                    oversize_error;
  } tlsd_result_t;

endpackage

### hdl/tlsd_in_reg.sv
// ----------------------------------------------------------------------------
// tlsd_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module tlsd_in_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tlsd_pkg::BYTE_BITS-1:0] rx_byte,
  input  logic                          take,
  output logic                          item_valid,
  output logic [tlsd_pkg::BYTE_BITS-1:0] item_byte
);
  import tlsd_pkg::*;

  assign in_stall = item_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      item_byte <= rx_byte;
    end
  end

endmodule

### hdl/tlsd_parser.sv
// ----------------------------------------------------------------------------
// tlsd_parser
// Header collection, length check, payload tagging and the result register.
// ----------------------------------------------------------------------------
module tlsd_parser #(
  parameter int LENGTH_BITS = tlsd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  logic [tlsd_pkg::BYTE_BITS-1:0] item_byte,
  output logic                           take,
  input  logic [tlsd_pkg::CFG_BITS-1:0]  max_len,
  output logic                           result_valid,
  input  logic                           out_stall,
  output tlsd_pkg::tlsd_result_t         result
);
  import tlsd_pkg::*;

  localparam logic [CFG_BITS-1:0] LEN_MASK = CFG_BITS'((64'd1 << LENGTH_BITS) - 64'd1);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALT    = 2'd2
  } phase_t;

  phase_t                   phase, phase_next;
  logic [HDR_CNT_BITS-1:0]  hdr_count, hdr_count_next;
  logic [TYPE_BITS-1:0]     type_reg, type_reg_next;
  logic [23:0]              len_acc, len_acc_next;
  logic [LEN_OUT_BITS-1:0]  cur_len, cur_len_next;
  logic [LENGTH_BITS-1:0]   remaining, remaining_next;
  logic [HDR_LEN_BITS-1:0]  full_len;
  logic [CFG_BITS-1:0]      max_eff;
  logic                     emit;
  tlsd_result_t             res_next;

  assign take     = item_valid && (!result_valid || !out_stall);
  assign full_len = {len_acc, item_byte};
  assign max_eff  = max_len & LEN_MASK;

  always_comb begin
    phase_next     = phase;
    hdr_count_next = hdr_count;
    type_reg_next  = type_reg;
    len_acc_next   = len_acc;
    cur_len_next   = cur_len;
    remaining_next = remaining;
    emit           = 1'b0;
    res_next       = '0;
    res_next.message_type = type_reg;
    unique case (phase)
      PH_HEADER: begin
        if (hdr_count < HDR_CNT_BITS'(TYPE_BYTES)) begin
          type_reg_next = {type_reg[7:0], item_byte};
        end else begin
          len_acc_next = {len_acc[15:0], item_byte};
        end
        hdr_count_next = hdr_count + 1'b1;
        if (hdr_count == HDR_CNT_BITS'(HDR_BYTES - 1)) begin
          hdr_count_next = '0;
          if (full_len[HDR_LEN_BITS-1] ||
              full_len > HDR_LEN_BITS'(max_eff) ||
              full_len > HDR_LEN_BITS'(HARD_MAX)) begin
            phase_next              = PH_HALT;
            emit                    = 1'b1;
            res_next.oversize_error = 1'b1;
            res_next.payload_length = (full_len > HDR_LEN_BITS'(HARD_MAX)) ?
                                      HARD_MAX : full_len[LEN_OUT_BITS-1:0];
          end else if (full_len == '0) begin
            emit          = 1'b1;
            res_next.last = 1'b1;
          end else begin
            phase_next     = PH_PAYLOAD;
            cur_len_next   = full_len[LEN_OUT_BITS-1:0];
            remaining_next = full_len[LENGTH_BITS-1:0];
          end
        end
      end
      PH_PAYLOAD: begin
        remaining_next          = remaining - 1'b1;
        emit                    = 1'b1;
        res_next.payload_length = cur_len;
        res_next.data_byte      = item_byte;
        res_next.has_data       = 1'b1;
        if (remaining == LENGTH_BITS'(1)) begin
          res_next.last  = 1'b1;
          phase_next     = PH_HEADER;
          hdr_count_next = '0;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      hdr_count    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        phase     <= phase_next;
        hdr_count <= hdr_count_next;
      end
      if (take && emit) begin
        result_valid <= 1'b1;
      end else if (!out_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (take) begin
      type_reg  <= type_reg_next;
      len_acc   <= len_acc_next;
      cur_len   <= cur_len_next;
      remaining <= remaining_next;
    end
    if (take && emit) begin
      result <= res_next;
    end
  end

endmodule

### hdl/type_length_stream_deframer_top.sv
// ----------------------------------------------------------------------------
// type_length_stream_deframer_top
// Splits a byte stream into type-length messages and tags each payload byte.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_stall     rx_byte
//   out      source     out_valid / out_stall   message_type, payload_length,
//                                               data_byte, has_data, last,
//                                               oversize_error
//   cfg      sink       max_payload_length_we   max_payload_length
//
// One byte per cycle sustained while out_stall is low; path: input register,
// parser logic, result register. Header bytes one to five give no item.
// rst is synchronous; it clears the parser, both valid flags and the
// maximum length (back to all ones), and it is the only way out of the
// halted state after an oversize error.
// out_stall holds the result register and, once the input register is also
// full, raises in_stall.
// ----------------------------------------------------------------------------
module type_length_stream_deframer_top #(
  parameter int LENGTH_BITS = tlsd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tlsd_pkg::BYTE_BITS-1:0]    rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tlsd_pkg::TYPE_BITS-1:0]    message_type,
  output logic [tlsd_pkg::LEN_OUT_BITS-1:0] payload_length,
  output logic [tlsd_pkg::BYTE_BITS-1:0]    data_byte,
  output logic                              has_data,
  output logic                              last,
  output logic                              oversize_error,
  input  logic                              max_payload_length_we,
  input  logic [tlsd_pkg::CFG_BITS-1:0]     max_payload_length
);
  import tlsd_pkg::*;

  logic                 take;
  logic                 item_valid;
  logic [BYTE_BITS-1:0] item_byte;
  logic [CFG_BITS-1:0]  max_len;
  tlsd_result_t         result;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= '1;
    end else if (max_payload_length_we) begin
      max_len <= max_payload_length;
    end
  end

  tlsd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .take       (take),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  tlsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_byte    (item_byte),
    .take         (take),
    .max_len      (max_len),
    .result_valid (out_valid),
    .out_stall    (out_stall),
    .result       (result)
  );

  assign message_type   = result.message_type;
  assign payload_length = result.payload_length;
  assign data_byte      = result.data_byte;
  assign has_data       = result.has_data;
  assign last           = result.last;
  assign oversize_error = result.oversize_error;

endmodule

### hdl/tlsd_checker.sv
// ----------------------------------------------------------------------------
// tlsd_checker
// Port-level checks on the deframer's result items.
// ----------------------------------------------------------------------------
module tlsd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [tlsd_pkg::LEN_OUT_BITS-1:0] payload_length,
  input logic [tlsd_pkg::BYTE_BITS-1:0]    data_byte,
  input logic                              has_data,
  input logic                              last,
  input logic                              oversize_error
);
  import tlsd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && oversize_error |=> !out_valid)
    else $error("item produced after oversize error");

  a_empty_msg: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_data && !oversize_error |-> last && payload_length == '0)
    else $error("empty message item malformed");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && oversize_error |-> !has_data && !last && data_byte == '0)
    else $error("error item carries data or last");

endmodule

bind type_length_stream_deframer_top tlsd_checker u_tlsd_checker (.*);

### tb/type_length_stream_deframer_top_test.sv
// ----------------------------------------------------------------------------
// type_length_stream_deframer_top_test
// Self-checking bench for the type-length stream deframer. A queue of bytes
// is built phase by phase: a few hand-picked messages, then random messages
// under several maximum-length settings (reset value, zero, one, a small
// value, all ones). The run ends with one bad header that halts the parser,
// followed by bytes that must be dropped. A local parser predicts every
// result item; the bench checks each one field by field against that
// prediction. Both sides idle at random, and the receiver holds off once for
// a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module type_length_stream_deframer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tlsd_pkg::*;

  typedef enum logic [1:0] {SEEK_HEADER, IN_BODY, HALTED} parse_phase_t;
  typedef enum int {NEG_LENGTH, OVER_HARD_MAX, OVER_LIMIT} bad_header_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [BYTE_BITS-1:0]    rx_byte = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [TYPE_BITS-1:0]    message_type;
  logic [LEN_OUT_BITS-1:0] payload_length;
  logic [BYTE_BITS-1:0]    data_byte;
  logic                    has_data;
  logic                    last;
  logic                    oversize_error;
  logic                    max_payload_length_we = 1'b0;
  logic [CFG_BITS-1:0]     max_payload_length = '0;

  type_length_stream_deframer_top dut (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .rx_byte               (rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .message_type          (message_type),
    .payload_length        (payload_length),
    .data_byte             (data_byte),
    .has_data              (has_data),
    .last                  (last),
    .oversize_error        (oversize_error),
    .max_payload_length_we (max_payload_length_we),
    .max_payload_length    (max_payload_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [BYTE_BITS-1:0] byte_queue[$];
  tlsd_result_t         expected_items[$];
  int unsigned          queued_count = 0;
  int unsigned          accepted_count = 0;
  int unsigned          results_seen = 0;
  int unsigned          mismatch_count = 0;
  bit                   steady = 1'b0;
  int unsigned          hold_left = 0;
  bit                   hold_done = 1'b0;

  // local copy of the parser state and the length limit
  parse_phase_t          parse_phase = SEEK_HEADER;
  logic [2:0]            hdr_count = '0;
  logic [TYPE_BITS-1:0]  type_acc = '0;
  logic [31:0]           len_acc = '0;
  logic [LEN_OUT_BITS-1:0] body_left = '0;
  logic [CFG_BITS-1:0]   limit_cfg = HARD_MAX;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < 40) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic bit deframe_byte(input logic [BYTE_BITS-1:0] b, output tlsd_result_t r);
    r = '0;
    case (parse_phase)
      SEEK_HEADER: begin
        if (hdr_count < TYPE_BYTES) type_acc = {type_acc[7:0], b};
        else len_acc = {len_acc[23:0], b};
        hdr_count++;
        if (hdr_count < HDR_BYTES) return 1'b0;
        hdr_count = '0;
        r.message_type = type_acc;
        if (len_acc[31] || len_acc > limit_cfg) begin
          parse_phase = HALTED;
          r.payload_length = (len_acc > HARD_MAX) ? HARD_MAX : len_acc[LEN_OUT_BITS-1:0];
          r.oversize_error = 1'b1;
          return 1'b1;
        end
        if (len_acc == 0) begin
          r.last = 1'b1;
          return 1'b1;
        end
        body_left = len_acc[LEN_OUT_BITS-1:0];
        parse_phase = IN_BODY;
        return 1'b0;
      end
      IN_BODY: begin
        body_left--;
        r.message_type = type_acc;
        r.payload_length = len_acc[LEN_OUT_BITS-1:0];
        r.data_byte = b;
        r.has_data = 1'b1;
        r.last = (body_left == 0);
        if (r.last) begin
          parse_phase = SEEK_HEADER;
          hdr_count = '0;
          len_acc = '0;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int unsigned pick_length(input int unsigned limit);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (limit == 0 || r < 12) return 0;
    if (r < 22) return (limit <= 40) ? limit : $urandom_range(1, 40);
    if (r < 80) return $urandom_range(1, (limit < 8) ? limit : 8);
    return $urandom_range(1, (limit < 40) ? limit : 40);
  endfunction

  task automatic push_byte(input logic [BYTE_BITS-1:0] b);
    byte_queue.push_back(b);
    queued_count++;
  endtask

  task automatic queue_header(input logic [TYPE_BITS-1:0] mtype, input logic [31:0] mlen);
    push_byte(mtype[15:8]);
    push_byte(mtype[7:0]);
    push_byte(mlen[31:24]);
    push_byte(mlen[23:16]);
    push_byte(mlen[15:8]);
    push_byte(mlen[7:0]);
  endtask

  task automatic queue_random_messages(input int unsigned budget);
    int unsigned start;
    int unsigned len;
    start = queued_count;
    while (queued_count - start < budget) begin
      len = pick_length(limit_cfg);
      queue_header(TYPE_BITS'($urandom), len);
      repeat (len) push_byte(BYTE_BITS'($urandom));
    end
  endtask

  task automatic settle();
    @(negedge clk);
    while (accepted_count != queued_count || expected_items.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_max_length(input logic [CFG_BITS-1:0] v);
    @(posedge clk);
    max_payload_length_we <= 1'b1;
    max_payload_length <= v;
    @(posedge clk);
    max_payload_length_we <= 1'b0;
    limit_cfg = v;
  endtask

  // driver: hold the item while stalled, advance otherwise
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (byte_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 24)) begin
        in_valid <= 1'b1;
        rx_byte <= byte_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long hold-off of the receiver, counted in cycles
  always @(posedge clk) begin : hold_off
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= 120) begin
      hold_done <= 1'b1;
      hold_left <= 200;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: predict on accepted input items, check accepted result items
  always @(posedge clk) begin : watch_items
    tlsd_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      parse_phase = SEEK_HEADER;
      hdr_count = '0;
      type_acc = '0;
      len_acc = '0;
      body_left = '0;
      limit_cfg = HARD_MAX;
    end else begin
      if (in_valid && !in_stall) begin
        accepted_count++;
        if (deframe_byte(rx_byte, want)) expected_items.push_back(want);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_items.size() == 0) begin
          flag_mismatch("result item with nothing expected");
        end else begin
          want = expected_items.pop_front();
          if (message_type !== want.message_type)
            flag_mismatch($sformatf("message_type %h, want %h", message_type, want.message_type));
          if (payload_length !== want.payload_length)
            flag_mismatch($sformatf("payload_length %h, want %h", payload_length,
                                    want.payload_length));
          if (data_byte !== want.data_byte)
            flag_mismatch($sformatf("data_byte %h, want %h", data_byte, want.data_byte));
          if (has_data !== want.has_data)
            flag_mismatch($sformatf("has_data %b, want %b", has_data, want.has_data));
          if (last !== want.last)
            flag_mismatch($sformatf("last %b, want %b", last, want.last));
          if (oversize_error !== want.oversize_error)
            flag_mismatch($sformatf("oversize_error %b, want %b", oversize_error,
                                    want.oversize_error));
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < 24);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    bad_header_t bad_kind;
    logic [31:0] bad_len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // hand-picked messages under the reset limit
    queue_header(16'hffff, 32'd0);
    queue_header(16'h0000, 32'd1);
    push_byte(8'hff);
    queue_header(16'h8001, 32'd2);
    push_byte(8'h00);
    push_byte(8'h80);
    queue_random_messages(420);
    settle();

    set_max_length('0);
    queue_random_messages(120);
    settle();

    steady = 1'b1;
    set_max_length(CFG_BITS'(1));
    queue_random_messages(150);
    settle();
    steady = 1'b0;

    set_max_length(CFG_BITS'($urandom_range(2, 60)));
    queue_random_messages(300);
    settle();

    set_max_length(HARD_MAX);
    queue_header(TYPE_BITS'($urandom), 32'd300);
    repeat (300) push_byte(BYTE_BITS'($urandom));
    queue_random_messages(100);
    settle();

    // one bad header halts the parser; everything after it is dropped
    bad_kind = bad_header_t'($urandom_range(0, 2));
    case (bad_kind)
      NEG_LENGTH: begin
        bad_len = {1'b1, 31'($urandom)};
      end
      OVER_HARD_MAX: begin
        bad_len = $urandom_range(32'h7fffffff, 32'h00800000);
      end
      default: begin
        set_max_length(CFG_BITS'($urandom_range(1, 50)));
        queue_header(TYPE_BITS'($urandom), limit_cfg);
        repeat (limit_cfg) push_byte(BYTE_BITS'($urandom));
        bad_len = limit_cfg + $urandom_range(1, 4);
      end
    endcase
    queue_header(TYPE_BITS'($urandom), bad_len);
    queue_header(TYPE_BITS'($urandom), 32'd0);
    repeat (24) push_byte(BYTE_BITS'($urandom));
    settle();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && expected_items.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
